[src/twg_pkg.sv]
// Shared constants, codes and the sine table of the table waveform generator.
package twg_pkg;

  localparam int unsigned TableDepth = 128;
  localparam int unsigned FullScale  = 400;
  localparam int unsigned AmpOne     = 1024;

  localparam int unsigned PhaseW  = $clog2(TableDepth);
  localparam int unsigned SampleW = $clog2(FullScale + 1);
  localparam int unsigned AmpW    = 11;
  localparam int unsigned DivW    = 8;
  localparam int unsigned AmpFrac = $clog2(AmpOne);
  localparam int unsigned HalfW   = $clog2(TableDepth / 2);

  localparam logic [SampleW-1:0] HalfScale = SampleW'(FullScale / 2);
  localparam logic [SampleW-1:0] TopScale  = SampleW'(2 * (FullScale / 2));
  localparam logic [AmpW-1:0]    AmpMax    = AmpW'(AmpOne);

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegWaveSel = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTickDiv = 2'd1;
  localparam logic [CfgIdxW-1:0] RegAmp     = 2'd2;

  typedef enum logic [1:0] {
    WaveSine     = 2'd0,
    WaveSquare   = 2'd1,
    WaveSawtooth = 2'd2,
    WaveTriangle = 2'd3
  } wave_e;

  localparam logic [SampleW-1:0] SineRom [TableDepth] = '{
    9'd200, 9'd209, 9'd219, 9'd229, 9'd239, 9'd248, 9'd258, 9'd267,
    9'd276, 9'd285, 9'd294, 9'd302, 9'd311, 9'd319, 9'd326, 9'd334,
    9'd341, 9'd348, 9'd354, 9'd360, 9'd366, 9'd371, 9'd376, 9'd380,
    9'd384, 9'd388, 9'd391, 9'd394, 9'd396, 9'd397, 9'd399, 9'd399,
    9'd400, 9'd399, 9'd399, 9'd397, 9'd396, 9'd394, 9'd391, 9'd388,
    9'd384, 9'd380, 9'd376, 9'd371, 9'd366, 9'd360, 9'd354, 9'd348,
    9'd341, 9'd334, 9'd326, 9'd319, 9'd311, 9'd302, 9'd294, 9'd285,
    9'd276, 9'd267, 9'd258, 9'd248, 9'd239, 9'd229, 9'd219, 9'd209,
    9'd200, 9'd190, 9'd180, 9'd170, 9'd160, 9'd151, 9'd141, 9'd132,
    9'd123, 9'd114, 9'd105, 9'd97,  9'd88,  9'd80,  9'd73,  9'd65,
    9'd58,  9'd51,  9'd45,  9'd39,  9'd33,  9'd28,  9'd23,  9'd19,
    9'd15,  9'd11,  9'd8,   9'd5,   9'd3,   9'd2,   9'd0,   9'd0,
    9'd0,   9'd0,   9'd0,   9'd2,   9'd3,   9'd5,   9'd8,   9'd11,
    9'd15,  9'd19,  9'd23,  9'd28,  9'd33,  9'd39,  9'd45,  9'd51,
    9'd58,  9'd65,  9'd73,  9'd80,  9'd88,  9'd97,  9'd105, 9'd114,
    9'd123, 9'd132, 9'd141, 9'd151, 9'd160, 9'd170, 9'd180, 9'd190
  };

endpackage

[src/table_waveform_generator.sv]
// Table waveform generator: tick divider, phase step, waveform lookup and scaling.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i/in_ready_o   tick_i
//   out       output     out_valid_o/out_ready_i compare_value_o, phase_index_o
//   cfg       input      cfg_we_i                cfg_index_i, cfg_data_i
//
// One transaction per cycle in while ready; a stepping tick passes through the
// phase register stage, then the table lookup and amplitude multiply into the
// output register. Reset clears the counters and loads the register defaults.
// A stalled output holds both stages; in_ready_o drops only when both are full.
module table_waveform_generator
  import twg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [AmpW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               tick_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SampleW-1:0] compare_value_o,
  output logic [PhaseW-1:0]  phase_index_o
);

  wave_e               wave_sel_q;
  logic [DivW-1:0]     tick_div_q;
  logic [AmpW-1:0]     amp_q;
  logic [DivW-1:0]     tick_count_q, tick_count_d, count_inc;
  logic [PhaseW-1:0]   phase_q, phase_d;
  logic                stage_valid_q;
  logic [PhaseW-1:0]   stage_phase_q;
  logic                out_valid_q;
  logic [SampleW-1:0]  out_value_q;
  logic [PhaseW-1:0]   out_phase_q;
  logic                out_adv, stage_adv, accept, step;
  logic [SampleW-1:0]  sine_s, sample;
  logic [HalfW:0]      tri_t;
  logic [SampleW+PhaseW-1:0] saw_prod, tri_prod;
  logic [AmpW-1:0]     amp_sat;
  logic [SampleW+AmpW-1:0]   scaled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_sel_q <= WaveSine;
      tick_div_q <= DivW'(1);
      amp_q      <= AmpMax;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegWaveSel: wave_sel_q <= wave_e'(cfg_data_i[1:0]);
        RegTickDiv: tick_div_q <= cfg_data_i[DivW-1:0];
        RegAmp:     amp_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_adv    = !out_valid_q || out_ready_i;
  assign stage_adv  = !stage_valid_q || out_adv;
  assign in_ready_o = stage_adv;
  assign accept     = in_valid_i && in_ready_o && tick_i;
  assign count_inc  = tick_count_q + DivW'(1);
  assign step       = accept && (count_inc >= tick_div_q);

  always_comb begin
    tick_count_d = tick_count_q;
    phase_d      = phase_q;
    if (accept) begin
      tick_count_d = step ? '0 : count_inc;
      if (step) begin
        phase_d = phase_q + PhaseW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q  <= '0;
      phase_q       <= '0;
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      tick_count_q <= tick_count_d;
      phase_q      <= phase_d;
      if (stage_adv) begin
        stage_valid_q <= step;
      end
      if (out_adv) begin
        out_valid_q <= stage_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_adv && step) begin
      stage_phase_q <= phase_d;
    end
    if (out_adv && stage_valid_q) begin
      out_value_q <= scaled[AmpFrac +: SampleW];
      out_phase_q <= stage_phase_q;
    end
  end

  assign sine_s   = SineRom[stage_phase_q];
  assign tri_t    = stage_phase_q[PhaseW-1] ? (HalfW+1)'(TableDepth - stage_phase_q)
                                            : (HalfW+1)'(stage_phase_q);
  assign saw_prod = TopScale * stage_phase_q;
  assign tri_prod = TopScale * tri_t;

  always_comb begin
    case (wave_sel_q)
      WaveSine:     sample = sine_s;
      WaveSquare:   sample = (sine_s > HalfScale) ? TopScale : '0;
      WaveSawtooth: sample = saw_prod[PhaseW +: SampleW];
      WaveTriangle: sample = tri_prod[HalfW +: SampleW];
      default:      sample = '0;
    endcase
  end

  assign amp_sat = (amp_q > AmpMax) ? AmpMax : amp_q;
  assign scaled  = sample * amp_sat;

  assign out_valid_o     = out_valid_q;
  assign compare_value_o = out_value_q;
  assign phase_index_o   = out_phase_q;

endmodule

[sim/table_waveform_generator_test.sv]
// Testbench for the table waveform generator: predicts the compare value of each phase step.
`timescale 1ns / 100ps

module table_waveform_generator_test;
  import twg_pkg::*;

  localparam int unsigned ResetCycles  = 12;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned RandomTicks  = 900;
  localparam int unsigned MaxIdle      = 17;
  localparam int unsigned LongHold     = 200;
  localparam int unsigned RomScale     = 400;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic [SampleW-1:0] level;
    logic [PhaseW-1:0]  index;
  } sample_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [AmpW-1:0]    cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic               tick_i      = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [SampleW-1:0] compare_value_o;
  logic [PhaseW-1:0]  phase_index_o;

  wave_e              cur_wave  = WaveSine;
  logic [DivW-1:0]    cur_div   = DivW'(1);
  logic [AmpW-1:0]    cur_amp   = AmpMax;
  logic [DivW-1:0]    cur_count = '0;
  logic [PhaseW-1:0]  cur_phase = '0;

  logic               pending_ticks[$];
  sample_t            expected_samples[$];
  sample_t            want;

  bit                 tx_idle = 1'b0;
  bit                 rx_idle = 1'b0;
  int unsigned        tx_wait = 0;
  int unsigned        rx_wait = 0;
  int unsigned        hold_requests = 0;
  int unsigned        hold_served = 0;
  int unsigned        cycles = 0;
  int unsigned        mismatches = 0;
  int unsigned        ticks_seen = 0;
  int unsigned        idle_ticks = 0;
  int unsigned        samples_checked = 0;
  int unsigned        phase_wraps = 0;
  int unsigned        settings = 0;

  table_waveform_generator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .tick_i          (tick_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .compare_value_o (compare_value_o),
    .phase_index_o   (phase_index_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic sample_t predict_sample(wave_e w, logic [PhaseW-1:0] idx,
                                             logic [AmpW-1:0] amp);
    int unsigned half;
    int unsigned gain;
    int unsigned s;
    int unsigned t;
    sample_t     r;
    half = FullScale / 2;
    gain = (amp > AmpOne) ? AmpOne : amp;
    case (w)
      WaveSine:     s = SineRom[idx] * FullScale / RomScale;
      WaveSquare:   s = (SineRom[idx] * FullScale / RomScale > half) ? 2 * half : 0;
      WaveSawtooth: s = 2 * half * idx / TableDepth;
      default: begin
        t = (idx < TableDepth / 2) ? idx : TableDepth - idx;
        s = 2 * half * t / (TableDepth / 2);
      end
    endcase
    r.level = SampleW'(s * gain / AmpOne);
    r.index = idx;
    return r;
  endfunction

  task automatic step_tick(input logic t);
    if (!t) begin
      idle_ticks++;
      return;
    end
    ticks_seen++;
    cur_count = cur_count + 1'b1;
    if (cur_count < cur_div) return;
    cur_count = '0;
    cur_phase = cur_phase + 1'b1;
    expected_samples.push_back(predict_sample(cur_wave, cur_phase, cur_amp));
  endtask

  // Driver: hold each transaction until accepted, then idle for the drawn gap.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tick_i     <= 1'b0;
      tx_wait    = 0;
      cur_count  = '0;
      cur_phase  = '0;
    end else begin
      if (in_valid_i && in_ready_o) step_tick(tick_i);
      if (!in_valid_i || in_ready_o) begin
        if (tx_wait != 0) begin
          tx_wait--;
          in_valid_i <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          in_valid_i <= 1'b1;
          tick_i     <= pending_ticks.pop_front();
          tx_wait    = tx_idle ? $urandom_range(0, MaxIdle) : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each sample, then stall for the drawn gap or a long hold.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_wait     = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        samples_checked++;
        if (phase_index_o == '0) phase_wraps++;
        if (expected_samples.size() == 0) begin
          mismatches++;
          $display("%0t: sample level %0d index %0d arrived with none expected",
                   $time, compare_value_o, phase_index_o);
        end else begin
          want = expected_samples.pop_front();
          if (compare_value_o !== want.level) begin
            mismatches++;
            $display("%0t: compare_value expected %0d actual %0d (index %0d)",
                     $time, want.level, compare_value_o, want.index);
          end
          if (phase_index_o !== want.index) begin
            mismatches++;
            $display("%0t: phase_index expected %0d actual %0d",
                     $time, want.index, phase_index_o);
          end
        end
        rx_wait = rx_idle ? $urandom_range(0, MaxIdle) : 0;
      end
      if (hold_served != hold_requests) begin
        hold_served++;
        rx_wait = LongHold;
      end
      if (rx_wait != 0) begin
        rx_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d samples outstanding",
               cycles, expected_samples.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [AmpW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      RegWaveSel: cur_wave = wave_e'(data[1:0]);
      RegTickDiv: cur_div  = data[DivW-1:0];
      RegAmp:     cur_amp  = data;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [AmpW-1:0] wave_data, div_data, amp_data);
    write_reg(RegWaveSel, wave_data);
    write_reg(RegTickDiv, div_data);
    write_reg(RegAmp, amp_data);
    write_reg(RegUnused, AmpW'($urandom));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic offer(input logic [31:0] pattern, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) pending_ticks.push_back(pattern[i]);
  endtask

  // Wait until every transaction is in and every sample out, then let the pipe settle.
  task automatic drain();
    do @(negedge clk_i);
    while (pending_ticks.size() != 0 || in_valid_i || expected_samples.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int unsigned     n;
    int unsigned     phase_no;
    int unsigned     random_ticks;
    int unsigned     pick;
    logic            t;
    logic [1:0]      wave;
    logic [DivW-1:0] div;
    logic [AmpW-1:0] amp;
    bit              squeeze;

    random_ticks = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults, a zero tick in the middle.
    offer(32'b11011, 5);
    drain();
    // Divider zero steps every tick; amplitude above one saturates.
    apply_setting(AmpW'(WaveSquare), '0, '1);
    offer(32'b1111, 4);
    drain();
    apply_setting('1, AmpW'(3), '0);
    offer(32'b0111111, 7);
    drain();
    apply_setting(11'h702, 11'h502, AmpW'(10));
    tx_idle <= 1'b1;
    rx_idle <= 1'b1;
    offer(32'b1111, 4);
    drain();

    phase_no = 0;
    while (random_ticks < RandomTicks) begin
      wave    = 2'($urandom);
      squeeze = (phase_no == 2) || ($urandom_range(0, 9) == 0);
      n       = $urandom_range(20, 90);
      if (phase_no == 0) begin
        div = 8'd255;
        n   = 300;
      end else if (phase_no == 1) begin
        div = 8'd200;
        n   = 210;
      end else if (squeeze) begin
        div = DivW'($urandom_range(0, 1));
      end else if ($urandom_range(0, 5) == 0) begin
        div = DivW'($urandom_range(7, 24));
      end else begin
        div = DivW'($urandom_range(0, 6));
      end
      pick = $urandom_range(0, 7);
      if (pick < 2) amp = AmpMax;
      else if (pick == 2) amp = AmpW'($urandom_range(AmpOne + 1, 2047));
      else if (pick == 3) amp = AmpW'(10);
      else amp = AmpW'($urandom_range(0, AmpOne - 1));
      apply_setting({(AmpW-2)'($urandom), wave}, {(AmpW-DivW)'($urandom), div}, amp);
      tx_idle <= squeeze ? 1'b0 : ($urandom_range(0, 2) != 0);
      rx_idle <= ($urandom_range(0, 2) != 0);
      if (squeeze) hold_requests <= hold_requests + 1;
      for (int unsigned i = 0; i < n; i++) begin
        t = ($urandom_range(0, 9) != 0);
        random_ticks++;
        pending_ticks.push_back(t);
      end
      drain();
      phase_no++;
    end

    $display("Ran %0d ticks and %0d idle ticks over %0d register settings",
             ticks_seen, idle_ticks, settings);
    $display("Checked %0d samples, %0d table wraps, %0d long output holds",
             samples_checked, phase_wraps, hold_served);
    if (mismatches == 0 && expected_samples.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
